// ----- hdl/slab_object_allocator_core_macros.svh -----
// Assertion macros for the slab object allocator.
// Depends on nothing; included by the top level only.
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SOA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("slab allocator assertion failed");
// Expression must never be true outside reset.
`define SOA_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("slab allocator forbidden condition seen");
`else
`define SOA_ASSERT(label, clk, rstn, prop)
`define SOA_NEVER(label, clk, rstn, expr)
`endif
`endif

// ----- hdl/soa_pkg.sv -----
// Shared types and constants of the slab object allocator.
// Depends on nothing; used by the top level only.
`timescale 1ns / 1ps
package soa_pkg;
  localparam int PAGE_SLOTS_DEF   = 16;
  localparam int OBJECT_SLOTS_DEF = 64;
  localparam int HANDLE_W         = 10;
  localparam int CFG_W            = 7;
  localparam int CNT_W            = 7;
  localparam int CMP_W            = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    LIST_FREE = 2'd0,
    LIST_USED = 2'd1,
    LIST_FULL = 2'd2,
    LIST_NONE = 2'd3
  } list_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PAGE    = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;
endpackage

// ----- hdl/soa_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module soa_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/slab_object_allocator_core.sv -----
// Slab object allocator: sequencer, per-page state and page list logic.
// Depends on soa_pkg, soa_ram and slab_object_allocator_core_macros.svh.
//
//   channel   handshake          beat contents
//   command   start / busy       command_i, object_handle_i
//   result    done_o strobe      result_handle_o, status_o, page_released_o
//   config    cfg_we_i           cfg_wdata_i (objects per page)
//
// An allocate that finds a page on the half-used or free list runs S_PICK, S_POP,
// S_POP_UPD and S_DONE before the result strobe; moving its page to another list
// adds the list move states. Claiming a fresh page first scans the page slots in
// S_SCAN, then links each object slot in S_FILL, as the shared link RAM port writes
// one link a cycle, and then puts the page on the free list.
// A free runs S_FREE, S_FREE_DEC and S_DONE, plus a list move, and an unlink
// when the page is released; a rejected free runs S_FREE and S_DONE. Reset clears
// all control and list state at once; the link RAM needs no clearing pass. The
// result beat is a one-cycle strobe and cannot be stalled.
`timescale 1ns / 1ps
`include "slab_object_allocator_core_macros.svh"
module slab_object_allocator_core import soa_pkg::*; #(
  parameter int PAGE_SLOTS   = PAGE_SLOTS_DEF,
  parameter int OBJECT_SLOTS = OBJECT_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                command_i,
  input  logic [HANDLE_W-1:0] object_handle_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                done_o,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic [1:0]          status_o,
  output logic                page_released_o
);
  localparam int PW = $clog2(PAGE_SLOTS);
  localparam int OW = $clog2(OBJECT_SLOTS);
  localparam int AW = $clog2(PAGE_SLOTS * OBJECT_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_PICK, S_SCAN, S_FILL, S_POP, S_POP_UPD, S_FREE, S_FREE_DEC,
    S_UN0, S_UN1, S_LK0, S_LK1, S_DONE
  } state_e;

  state_e            state_q, ret_q;
  logic [CFG_W-1:0]  cfg_q;
  logic              bad_q, lonly_q;
  list_e             lst_q;
  logic [PW-1:0]     page_q, scan_q, pn_q, pp_q, oh_q;
  logic              pnv_q, ppv_q, ohv_q;
  logic [OW-1:0]     obj_q, fill_q;
  logic              done_q, rel_q;
  logic [HANDLE_W-1:0] res_q;
  status_e           status_q;

  // Per-page state, held in flops.
  logic              claimed_q [PAGE_SLOTS];
  logic [CNT_W-1:0]  count_q   [PAGE_SLOTS];
  logic [OW-1:0]     top_q     [PAGE_SLOTS];
  logic              topv_q    [PAGE_SLOTS];
  logic [PW-1:0]     next_q    [PAGE_SLOTS];
  logic              nextv_q   [PAGE_SLOTS];
  logic [PW-1:0]     prev_q    [PAGE_SLOTS];
  logic              prevv_q   [PAGE_SLOTS];
  list_e             plist_q   [PAGE_SLOTS];
  logic [PW-1:0]     head_q    [3];
  logic              headv_q   [3];

  // Effective capacity, clamped to 2..OBJECT_SLOTS.
  logic [CMP_W-1:0] cap, half, cnt_x;
  always_comb begin
    if (cfg_q < CFG_W'(2)) begin
      cap = CMP_W'(2);
    end else if (CMP_W'(cfg_q) > CMP_W'(OBJECT_SLOTS)) begin
      cap = CMP_W'(OBJECT_SLOTS);
    end else begin
      cap = CMP_W'(cfg_q);
    end
    half  = cap >> 1;
    cnt_x = CMP_W'(count_q[page_q]);
  end

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] p, logic [OW-1:0] o);
    addr_of = AW'(32'(p) * 32'(OBJECT_SLOTS) + 32'(o));
  endfunction

  // Object link RAM: one stack link plus its valid bit per object slot.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [OW:0]     ram_wdata, ram_rdata;
  logic            free_ok;

  assign free_ok = !bad_q && claimed_q[page_q] && (CMP_W'(obj_q) < cap);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(page_q, obj_q);
    ram_wdata = {topv_q[page_q], top_q[page_q]};
    ram_raddr = addr_of(page_q, top_q[page_q]);
    case (state_q)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(page_q, fill_q);
        ram_wdata = {fill_q != '0, fill_q - OW'(1)};
      end
      S_FREE: begin
        ram_we = free_ok;
      end
      default: ;
    endcase
  end

  soa_ram #(.WIDTH(OW + 1), .DEPTH(PAGE_SLOTS * OBJECT_SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = (count_q[page_q] != CNT_MAX) ? count_q[page_q] + CNT_W'(1)
                                                : count_q[page_q];

  // Sequencer. List moves run as a small subroutine (S_UN0 .. S_LK1) that
  // returns to ret_q; an unlink-only call returns after S_UN1, or after S_UN0 if on no list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      cfg_q    <= CFG_RESET;
      bad_q    <= 1'b0;
      lonly_q  <= 1'b0;
      lst_q    <= LIST_FREE;
      page_q   <= '0;
      scan_q   <= '0;
      pn_q     <= '0;
      pp_q     <= '0;
      oh_q     <= '0;
      pnv_q    <= 1'b0;
      ppv_q    <= 1'b0;
      ohv_q    <= 1'b0;
      obj_q    <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      rel_q    <= 1'b0;
      res_q    <= '0;
      status_q <= ST_OK;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        claimed_q[i] <= 1'b0;
        count_q[i]   <= '0;
        top_q[i]     <= '0;
        topv_q[i]    <= 1'b0;
        next_q[i]    <= '0;
        nextv_q[i]   <= 1'b0;
        prev_q[i]    <= '0;
        prevv_q[i]   <= 1'b0;
        plist_q[i]   <= LIST_NONE;
      end
      for (int i = 0; i < 3; i++) begin
        head_q[i]  <= '0;
        headv_q[i] <= 1'b0;
      end
    end else begin
      done_q <= (state_q == S_DONE);
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            page_q   <= PW'(32'(object_handle_i) / OBJECT_SLOTS);
            obj_q    <= OW'(32'(object_handle_i) % OBJECT_SLOTS);
            bad_q    <= (32'(object_handle_i) / OBJECT_SLOTS) >= PAGE_SLOTS;
            res_q    <= '0;
            status_q <= ST_OK;
            rel_q    <= 1'b0;
            state_q  <= (command_i == CMD_FREE) ? S_FREE : S_PICK;
          end
        end
        S_PICK: begin
          if (headv_q[LIST_USED]) begin
            page_q  <= head_q[LIST_USED];
            state_q <= S_POP;
          end else if (headv_q[LIST_FREE]) begin
            page_q  <= head_q[LIST_FREE];
            state_q <= S_POP;
          end else begin
            scan_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!claimed_q[scan_q]) begin
            page_q  <= scan_q;
            fill_q  <= '0;
            state_q <= S_FILL;
          end else if (scan_q == PW'(PAGE_SLOTS - 1)) begin
            status_q <= ST_NO_PAGE;
            state_q  <= S_DONE;
          end else begin
            scan_q <= scan_q + PW'(1);
          end
        end
        S_FILL: begin
          // The RAM write of this slot's link happens in this cycle.
          if (CMP_W'(fill_q) == cap - CMP_W'(1)) begin
            top_q[page_q]     <= OW'(cap - CMP_W'(1));
            topv_q[page_q]    <= 1'b1;
            claimed_q[page_q] <= 1'b1;
            count_q[page_q]   <= '0;
            plist_q[page_q]   <= LIST_NONE;
            lst_q             <= LIST_FREE;
            lonly_q           <= 1'b0;
            ret_q             <= S_POP;
            state_q           <= S_UN0;
          end else begin
            fill_q <= fill_q + OW'(1);
          end
        end
        S_POP: begin
          if (!topv_q[page_q]) begin
            status_q <= ST_NO_PAGE;
            state_q  <= S_DONE;
          end else begin
            obj_q   <= top_q[page_q];
            state_q <= S_POP_UPD;
          end
        end
        S_POP_UPD: begin
          top_q[page_q]   <= ram_rdata[OW-1:0];
          topv_q[page_q]  <= ram_rdata[OW];
          count_q[page_q] <= cnt_inc;
          res_q           <= HANDLE_W'(32'(page_q) * 32'(OBJECT_SLOTS) + 32'(obj_q));
          lonly_q         <= 1'b0;
          ret_q           <= S_DONE;
          if (CMP_W'(cnt_inc) == half) begin
            lst_q   <= LIST_USED;
            state_q <= S_UN0;
          end else if (CMP_W'(cnt_inc) == cap) begin
            lst_q   <= LIST_FULL;
            state_q <= S_UN0;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FREE: begin
          if (!free_ok) begin
            status_q <= ST_NOT_IN_USE;
            state_q  <= S_DONE;
          end else begin
            top_q[page_q]  <= obj_q;
            topv_q[page_q] <= 1'b1;
            lonly_q        <= 1'b0;
            ret_q          <= S_FREE_DEC;
            if (cnt_x == cap) begin
              lst_q   <= LIST_USED;
              state_q <= S_UN0;
            end else if (cnt_x == half) begin
              lst_q   <= LIST_FREE;
              state_q <= S_UN0;
            end else begin
              state_q <= S_FREE_DEC;
            end
          end
        end
        S_FREE_DEC: begin
          if (count_q[page_q] <= CNT_W'(1)) begin
            // The page empties and goes back to the pool.
            count_q[page_q]   <= '0;
            claimed_q[page_q] <= 1'b0;
            topv_q[page_q]    <= 1'b0;
            rel_q             <= 1'b1;
            lonly_q           <= 1'b1;
            ret_q             <= S_DONE;
            state_q           <= S_UN0;
          end else begin
            count_q[page_q] <= count_q[page_q] - CNT_W'(1);
            state_q         <= S_DONE;
          end
        end
        S_UN0: begin
          if (plist_q[page_q] == LIST_NONE) begin
            state_q <= lonly_q ? ret_q : S_LK0;
          end else begin
            pn_q  <= next_q[page_q];
            pnv_q <= nextv_q[page_q];
            pp_q  <= prev_q[page_q];
            ppv_q <= prevv_q[page_q];
            if (prevv_q[page_q]) begin
              next_q[prev_q[page_q]]  <= next_q[page_q];
              nextv_q[prev_q[page_q]] <= nextv_q[page_q];
            end else begin
              head_q[plist_q[page_q]]  <= next_q[page_q];
              headv_q[plist_q[page_q]] <= nextv_q[page_q];
            end
            state_q <= S_UN1;
          end
        end
        S_UN1: begin
          if (pnv_q) begin
            prev_q[pn_q]  <= pp_q;
            prevv_q[pn_q] <= ppv_q;
          end
          plist_q[page_q] <= LIST_NONE;
          state_q         <= lonly_q ? ret_q : S_LK0;
        end
        S_LK0: begin
          prevv_q[page_q] <= 1'b0;
          prev_q[page_q]  <= '0;
          next_q[page_q]  <= head_q[lst_q];
          nextv_q[page_q] <= headv_q[lst_q];
          oh_q            <= head_q[lst_q];
          ohv_q           <= headv_q[lst_q];
          head_q[lst_q]   <= page_q;
          headv_q[lst_q]  <= 1'b1;
          plist_q[page_q] <= lst_q;
          state_q         <= S_LK1;
        end
        S_LK1: begin
          if (ohv_q) begin
            prev_q[oh_q]  <= page_q;
            prevv_q[oh_q] <= 1'b1;
          end
          state_q <= ret_q;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign result_handle_o = res_q;
  assign status_o        = status_q;
  assign page_released_o = rel_q;

  // The result beat is shown while the sequencer is back in idle.
  `SOA_NEVER(a_done_idle, clk_i, rst_ni, done_o && busy)
  // An accepted command always occupies the sequencer on the next cycle.
  `SOA_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // A released page only comes from a successful free.
  `SOA_ASSERT(a_rel_ok, clk_i, rst_ni, (done_o && page_released_o) |-> (status_o == ST_OK))
  // Failed commands never report a handle.
  `SOA_ASSERT(a_fail_zero, clk_i, rst_ni,
    (done_o && status_o != ST_OK) |-> (result_handle_o == '0))
endmodule
